FILE: rtl/lis_pkg.sv
package lis_pkg;

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_DROP  = 3'd5,
        OP_CLEAR = 3'd6
    } op_t;

    // control bits that ride along with an access token down the cell row
    typedef struct packed {
        logic valid;    // token present at this stage
        logic pending;  // entry access not yet performed
        logic we;       // access is a write
    } ctl_t;

    localparam int OP_W    = 3;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 8;
    localparam int DROP_W  = 9;
    localparam int DEPTH_W = 9;
    localparam int WIDE_W  = 64;

endpackage

FILE: rtl/lis_cell.sv
module lis_cell #(
    parameter int WORD_WIDTH = 32,
    parameter int ADDR_W     = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lis_pkg::ctl_t         ctl_in,
    input  logic [ADDR_W-1:0]     addr_in,
    input  logic [WORD_WIDTH-1:0] wdata_in,
    input  logic [WORD_WIDTH-1:0] rdata_in,
    output lis_pkg::ctl_t         ctl_out,
    output logic [ADDR_W-1:0]     addr_out,
    output logic [WORD_WIDTH-1:0] wdata_out,
    output logic [WORD_WIDTH-1:0] rdata_out
);

    logic [WORD_WIDTH-1:0] entry_reg;
    lis_pkg::ctl_t         ctl_reg;
    lis_pkg::ctl_t         ctl_next;
    logic [ADDR_W-1:0]     addr_reg;
    logic [WORD_WIDTH-1:0] wdata_reg;
    logic [WORD_WIDTH-1:0] rdata_reg;
    logic [WORD_WIDTH-1:0] rdata_next;
    logic                  hit;

    // the token counts its address down; the cell it reaches at zero owns the access
    assign hit = ctl_in.valid && ctl_in.pending && (addr_in == '0);

    always_comb
    begin
        ctl_next         = ctl_in;
        ctl_next.pending = ctl_in.pending && !hit;
        rdata_next       = (hit && !ctl_in.we) ? entry_reg : rdata_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_in - ADDR_W'(1);
        wdata_reg <= wdata_in;
        rdata_reg <= rdata_next;
        if (hit && ctl_in.we)
        begin
            entry_reg <= wdata_in;
        end
    end

    assign ctl_out   = ctl_reg;
    assign addr_out  = addr_reg;
    assign wdata_out = wdata_reg;
    assign rdata_out = rdata_reg;

endmodule

FILE: rtl/indexed_lifo_stack_top.sv
// Indexed LIFO stack built as a row of STACK_DEPTH cells, one entry per cell.
// A command is taken when start is high and busy is low; the depth and the
// success flag are settled at once, and an access token then walks the row one
// cell per cycle, writing or reading the addressed entry on its way. The result
// appears on read_data/ok/depth_now with done high for exactly one cycle,
// once the token has passed the last cell; busy stays high until then. A new
// command may be issued in the cycle done is high, so commands are taken one
// at a time, paced by the token's trip through the row.
// There is no way to hold a result off: capture it in the done cycle.
// Entries come up undefined after reset; only entries below the depth are read.
module indexed_lifo_stack_top #(
    parameter int STACK_DEPTH = 256,
    parameter int WORD_WIDTH  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [lis_pkg::OP_W-1:0]     operation,
    input  logic [lis_pkg::DATA_W-1:0]   data_value,
    input  logic [lis_pkg::POS_W-1:0]    position,
    input  logic [lis_pkg::DROP_W-1:0]   drop_count,
    output logic                         done,
    output logic [lis_pkg::DATA_W-1:0]   read_data,
    output logic                         ok,
    output logic [lis_pkg::DEPTH_W-1:0]  depth_now
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int EXT_W  = (CNT_W > lis_pkg::DEPTH_W) ? CNT_W : lis_pkg::DEPTH_W;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                      state_reg;
    logic [CNT_W-1:0]            fill_reg;
    logic [CNT_W-1:0]            fill_next;
    logic                        ok_reg;
    logic                        ok_next;
    logic                        done_reg;
    logic [lis_pkg::DATA_W-1:0]  rdata_reg;
    lis_pkg::ctl_t               launch_ctl_reg;
    lis_pkg::ctl_t               launch_ctl_next;
    logic [ADDR_W-1:0]           launch_addr_reg;
    logic [ADDR_W-1:0]           launch_addr_next;
    logic [WORD_WIDTH-1:0]       launch_wdata_reg;

    logic                        accept;
    logic [EXT_W-1:0]            fill_ext;
    logic [EXT_W-1:0]            pos_ext;
    logic [EXT_W-1:0]            drop_ext;
    logic [EXT_W-1:0]            top_ext;
    logic [EXT_W-1:0]            left_ext;
    logic [lis_pkg::WIDE_W-1:0]  wdata_wide;
    logic [lis_pkg::WIDE_W-1:0]  rdata_wide;

    lis_pkg::ctl_t               ctl_w   [STACK_DEPTH];
    logic [ADDR_W-1:0]           addr_w  [STACK_DEPTH];
    logic [WORD_WIDTH-1:0]       wdata_w [STACK_DEPTH];
    logic [WORD_WIDTH-1:0]       rdata_w [STACK_DEPTH];

    assign busy   = (state_reg == ST_RUN);
    assign accept = start && !busy;

    assign fill_ext   = EXT_W'(fill_reg);
    assign pos_ext    = EXT_W'(position);
    assign drop_ext   = EXT_W'(drop_count);
    assign top_ext    = fill_ext - EXT_W'(1);
    assign left_ext   = fill_ext - drop_ext;
    assign wdata_wide = lis_pkg::WIDE_W'(data_value);

    always_comb
    begin
        fill_next        = fill_reg;
        ok_next          = 1'b0;
        launch_ctl_next  = '0;
        launch_addr_next = '0;
        unique case (operation)
            lis_pkg::OP_PUSH:
            begin
                if (fill_ext < EXT_W'(STACK_DEPTH))
                begin
                    ok_next                 = 1'b1;
                    fill_next               = fill_reg + CNT_W'(1);
                    launch_ctl_next.pending = 1'b1;
                    launch_ctl_next.we      = 1'b1;
                    launch_addr_next        = fill_ext[ADDR_W-1:0];
                end
            end
            lis_pkg::OP_POP, lis_pkg::OP_PEEK:
            begin
                if (fill_ext != '0)
                begin
                    ok_next                 = 1'b1;
                    launch_ctl_next.pending = 1'b1;
                    launch_addr_next        = top_ext[ADDR_W-1:0];
                    if (operation == lis_pkg::OP_POP)
                    begin
                        fill_next = top_ext[CNT_W-1:0];
                    end
                end
            end
            lis_pkg::OP_WRITE, lis_pkg::OP_READ:
            begin
                if (pos_ext < fill_ext)
                begin
                    ok_next                 = 1'b1;
                    launch_ctl_next.pending = 1'b1;
                    launch_ctl_next.we      = (operation == lis_pkg::OP_WRITE);
                    launch_addr_next        = pos_ext[ADDR_W-1:0];
                end
            end
            lis_pkg::OP_DROP:
            begin
                if (drop_ext <= fill_ext)
                begin
                    ok_next   = 1'b1;
                    fill_next = left_ext[CNT_W-1:0];
                end
            end
            lis_pkg::OP_CLEAR:
            begin
                ok_next   = 1'b1;
                fill_next = '0;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
        launch_ctl_next.valid = 1'b1;
    end

    assign rdata_wide = lis_pkg::WIDE_W'(rdata_w[STACK_DEPTH-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            done_reg       <= 1'b0;
            ok_reg         <= 1'b0;
            rdata_reg      <= '0;
            launch_ctl_reg <= '0;
        end
        else
        begin
            done_reg       <= 1'b0;
            launch_ctl_reg <= '0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg      <= ST_RUN;
                        fill_reg       <= fill_next;
                        ok_reg         <= ok_next;
                        launch_ctl_reg <= launch_ctl_next;
                    end
                end
                ST_RUN:
                begin
                    if (ctl_w[STACK_DEPTH-1].valid)
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                        rdata_reg <= rdata_wide[lis_pkg::DATA_W-1:0];
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            launch_addr_reg  <= launch_addr_next;
            launch_wdata_reg <= wdata_wide[WORD_WIDTH-1:0];
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                lis_cell #(
                    .WORD_WIDTH (WORD_WIDTH),
                    .ADDR_W     (ADDR_W)
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctl_in    (launch_ctl_reg),
                    .addr_in   (launch_addr_reg),
                    .wdata_in  (launch_wdata_reg),
                    .rdata_in  ({WORD_WIDTH{1'b0}}),
                    .ctl_out   (ctl_w[gi]),
                    .addr_out  (addr_w[gi]),
                    .wdata_out (wdata_w[gi]),
                    .rdata_out (rdata_w[gi])
                );
            end
            else
            begin : g_body
                lis_cell #(
                    .WORD_WIDTH (WORD_WIDTH),
                    .ADDR_W     (ADDR_W)
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctl_in    (ctl_w[gi-1]),
                    .addr_in   (addr_w[gi-1]),
                    .wdata_in  (wdata_w[gi-1]),
                    .rdata_in  (rdata_w[gi-1]),
                    .ctl_out   (ctl_w[gi]),
                    .addr_out  (addr_w[gi]),
                    .wdata_out (wdata_w[gi]),
                    .rdata_out (rdata_w[gi])
                );
            end
        end
    endgenerate

    assign done      = done_reg;
    assign ok        = ok_reg;
    assign read_data = rdata_reg;
    assign depth_now = fill_ext[lis_pkg::DEPTH_W-1:0];

endmodule

FILE: rtl/lis_checker.sv
module lis_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic                        ok,
    input logic [lis_pkg::DATA_W-1:0]  read_data
);

    // a result is never shown twice in a row: every command walks the whole row
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done high for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a taken command");

    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (read_data == '0))
        else $error("refused transaction returned nonzero data");

endmodule

bind indexed_lifo_stack_top lis_checker u_lis_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .ok        (ok),
    .read_data (read_data)
);

FILE: tb/indexed_lifo_stack_top_test.sv
module indexed_lifo_stack_top_test;

    localparam int STACK_CAP   = 256;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_ITEMS = 800;
    localparam int QUIET_TAIL   = 100;

    localparam logic [lis_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

    typedef enum int {
        MIX_MODE,
        FILL_MODE
    } gen_mode_t;

    typedef struct packed {
        logic [lis_pkg::DATA_W-1:0]  rd;
        logic                        ok;
        logic [lis_pkg::DEPTH_W-1:0] depth;
    } stack_result_t;

    typedef struct packed {
        logic [lis_pkg::OP_W-1:0]   op;
        logic [lis_pkg::DATA_W-1:0] data;
        logic [lis_pkg::POS_W-1:0]  pos;
        logic [lis_pkg::DROP_W-1:0] cnt;
        logic                       typed;
        stack_result_t              res;
    } stim_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [lis_pkg::OP_W-1:0]     operation;
    logic [lis_pkg::DATA_W-1:0]   data_value;
    logic [lis_pkg::POS_W-1:0]    position;
    logic [lis_pkg::DROP_W-1:0]   drop_count;
    logic                         done;
    logic [lis_pkg::DATA_W-1:0]   read_data;
    logic                         ok;
    logic [lis_pkg::DEPTH_W-1:0]  depth_now;

    logic [lis_pkg::DATA_W-1:0]   model_entries [STACK_CAP];
    int                           model_depth;
    stack_result_t                pending_results [$];
    int                           mismatch_count;

    // rows marked typed carry a hand-written result; the rest go through the predictor
    stim_row_t directed_rows [25] = '{
        '{lis_pkg::OP_POP,   32'h0,        8'd0,   9'd0,   1'b1, '{32'h0, 1'b0, 9'd0}},
        '{lis_pkg::OP_PEEK,  32'h0,        8'd0,   9'd0,   1'b1, '{32'h0, 1'b0, 9'd0}},
        '{lis_pkg::OP_READ,  32'h0,        8'd0,   9'd0,   1'b1, '{32'h0, 1'b0, 9'd0}},
        '{lis_pkg::OP_WRITE, 32'hFFFFFFFF, 8'd255, 9'd0,   1'b1, '{32'h0, 1'b0, 9'd0}},
        '{lis_pkg::OP_DROP,  32'h0,        8'd0,   9'd1,   1'b1, '{32'h0, 1'b0, 9'd0}},
        '{lis_pkg::OP_DROP,  32'h0,        8'd0,   9'd0,   1'b1, '{32'h0, 1'b1, 9'd0}},
        '{lis_pkg::OP_CLEAR, 32'h0,        8'd0,   9'd0,   1'b1, '{32'h0, 1'b1, 9'd0}},
        '{OP_UNUSED,         32'hFFFFFFFF, 8'd255, 9'd256, 1'b1, '{32'h0, 1'b0, 9'd0}},
        '{lis_pkg::OP_PUSH,  32'hFFFFFFFF, 8'd0,   9'd0,   1'b1, '{32'h0, 1'b1, 9'd1}},
        '{lis_pkg::OP_PEEK,  32'h0,        8'd0,   9'd0,   1'b1, '{32'hFFFFFFFF, 1'b1, 9'd1}},
        '{lis_pkg::OP_PUSH,  32'h0,        8'd0,   9'd0,   1'b1, '{32'h0, 1'b1, 9'd2}},
        '{lis_pkg::OP_READ,  32'h0,        8'd0,   9'd0,   1'b1, '{32'hFFFFFFFF, 1'b1, 9'd2}},
        '{lis_pkg::OP_WRITE, 32'hA5A5A5A5, 8'd1,   9'd0,   1'b1, '{32'h0, 1'b1, 9'd2}},
        '{lis_pkg::OP_READ,  32'h0,        8'd1,   9'd0,   1'b1, '{32'hA5A5A5A5, 1'b1, 9'd2}},
        '{lis_pkg::OP_READ,  32'h0,        8'd255, 9'd0,   1'b1, '{32'h0, 1'b0, 9'd2}},
        '{lis_pkg::OP_WRITE, 32'h5A5A5A5A, 8'd2,   9'd0,   1'b1, '{32'h0, 1'b0, 9'd2}},
        '{lis_pkg::OP_DROP,  32'h0,        8'd0,   9'd256, 1'b1, '{32'h0, 1'b0, 9'd2}},
        '{lis_pkg::OP_DROP,  32'h0,        8'd0,   9'd3,   1'b1, '{32'h0, 1'b0, 9'd2}},
        '{lis_pkg::OP_PUSH,  32'h5A5A5A5A, 8'd0,   9'd0,   1'b0, '0},
        '{lis_pkg::OP_DROP,  32'h0,        8'd0,   9'd0,   1'b0, '0},
        '{lis_pkg::OP_POP,   32'h0,        8'd0,   9'd0,   1'b0, '0},
        '{lis_pkg::OP_DROP,  32'h0,        8'd0,   9'd2,   1'b1, '{32'h0, 1'b1, 9'd0}},
        '{lis_pkg::OP_POP,   32'h0,        8'd0,   9'd0,   1'b1, '{32'h0, 1'b0, 9'd0}},
        '{lis_pkg::OP_PUSH,  32'h12345678, 8'd0,   9'd0,   1'b0, '0},
        '{lis_pkg::OP_CLEAR, 32'h0,        8'd0,   9'd0,   1'b1, '{32'h0, 1'b1, 9'd0}}
    };

    indexed_lifo_stack_top #(
        .STACK_DEPTH(STACK_CAP),
        .WORD_WIDTH (lis_pkg::DATA_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .data_value(data_value),
        .position  (position),
        .drop_count(drop_count),
        .done      (done),
        .read_data (read_data),
        .ok        (ok),
        .depth_now (depth_now)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic stack_result_t apply_stack_op(
        input logic [lis_pkg::OP_W-1:0]   op,
        input logic [lis_pkg::DATA_W-1:0] data,
        input logic [lis_pkg::POS_W-1:0]  pos,
        input logic [lis_pkg::DROP_W-1:0] cnt);
        stack_result_t r;
        r = '0;
        case (op)
            lis_pkg::OP_PUSH:
                if (model_depth < STACK_CAP)
                begin
                    model_entries[model_depth] = data;
                    model_depth++;
                    r.ok = 1'b1;
                end
            lis_pkg::OP_POP:
                if (model_depth > 0)
                begin
                    model_depth--;
                    r.rd = model_entries[model_depth];
                    r.ok = 1'b1;
                end
            lis_pkg::OP_PEEK:
                if (model_depth > 0)
                begin
                    r.rd = model_entries[model_depth - 1];
                    r.ok = 1'b1;
                end
            lis_pkg::OP_WRITE:
                if (int'(pos) < model_depth)
                begin
                    model_entries[pos] = data;
                    r.ok = 1'b1;
                end
            lis_pkg::OP_READ:
                if (int'(pos) < model_depth)
                begin
                    r.rd = model_entries[pos];
                    r.ok = 1'b1;
                end
            lis_pkg::OP_DROP:
                if (int'(cnt) <= model_depth)
                begin
                    model_depth -= int'(cnt);
                    r.ok = 1'b1;
                end
            lis_pkg::OP_CLEAR:
            begin
                model_depth = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.depth = model_depth[lis_pkg::DEPTH_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] %s", $realtime, what);
        mismatch_count++;
    endtask

    // results cannot be held off, so every done cycle is a transaction
    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result rd=%h ok=%b depth=%0d",
                                          read_data, ok, depth_now));
            else
            begin
                want = pending_results.pop_front();
                if (read_data !== want.rd || ok !== want.ok || depth_now !== want.depth)
                    report_mismatch($sformatf(
                        "result: expected rd=%h ok=%b depth=%0d, got rd=%h ok=%b depth=%0d",
                        want.rd, want.ok, want.depth, read_data, ok, depth_now));
            end
        end
    end

    // called at a rising edge; returns at the edge the command was taken, or after a gap
    task automatic send_command(input logic [lis_pkg::OP_W-1:0]   op,
                                input logic [lis_pkg::DATA_W-1:0] data,
                                input logic [lis_pkg::POS_W-1:0]  pos,
                                input logic [lis_pkg::DROP_W-1:0] cnt,
                                input logic typed, input stack_result_t typed_res,
                                input bit may_idle);
        stack_result_t predicted;
        int gap;
        operation  <= op;
        data_value <= data;
        position   <= pos;
        drop_count <= cnt;
        start      <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = apply_stack_op(op, data, pos, cnt);
        pending_results.push_back(typed ? typed_res : predicted);
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            if ($urandom_range(0, 1) == 0)
                repeat (gap) @(posedge clk);
            else
            begin
                // idle across the point where the block frees up
                @(posedge clk);
                while (busy !== 1'b0)
                    @(posedge clk);
                repeat (gap - 1) @(posedge clk);
            end
        end
    endtask

    task automatic pick_command(input gen_mode_t mode,
                                output logic [lis_pkg::OP_W-1:0]   op,
                                output logic [lis_pkg::DATA_W-1:0] data,
                                output logic [lis_pkg::POS_W-1:0]  pos,
                                output logic [lis_pkg::DROP_W-1:0] cnt);
        int r;
        int lim;
        r = $urandom_range(0, 99);
        if (mode == FILL_MODE)
        begin
            if (r < 80)      op = lis_pkg::OP_PUSH;
            else if (r < 88) op = lis_pkg::OP_READ;
            else if (r < 94) op = lis_pkg::OP_WRITE;
            else if (r < 97) op = lis_pkg::OP_PEEK;
            else             op = lis_pkg::OP_POP;
        end
        else
        begin
            if (r < 26)      op = lis_pkg::OP_PUSH;
            else if (r < 44) op = lis_pkg::OP_POP;
            else if (r < 54) op = lis_pkg::OP_PEEK;
            else if (r < 68) op = lis_pkg::OP_WRITE;
            else if (r < 84) op = lis_pkg::OP_READ;
            else if (r < 95) op = lis_pkg::OP_DROP;
            else if (r < 98) op = lis_pkg::OP_CLEAR;
            else             op = OP_UNUSED;
        end

        r = $urandom_range(0, 9);
        if (r == 0)      data = '0;
        else if (r == 1) data = '1;
        else             data = $urandom;

        if (model_depth > 0 && $urandom_range(0, 3) != 0)
            pos = lis_pkg::POS_W'($urandom_range(0, model_depth - 1));
        else
            pos = lis_pkg::POS_W'($urandom_range(0, STACK_CAP - 1));

        r = $urandom_range(0, 9);
        lim = (model_depth < 8) ? model_depth : 8;
        case (r)
            0:       cnt = '0;
            1:       cnt = lis_pkg::DROP_W'(model_depth);
            2:       cnt = lis_pkg::DROP_W'(STACK_CAP);
            3:       cnt = lis_pkg::DROP_W'($urandom_range(0, STACK_CAP));
            default: cnt = lis_pkg::DROP_W'($urandom_range(0, lim + 1));
        endcase
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [lis_pkg::OP_W-1:0]   op;
        logic [lis_pkg::DATA_W-1:0] data;
        logic [lis_pkg::POS_W-1:0]  pos;
        logic [lis_pkg::DROP_W-1:0] cnt;
        int                         issued;
        int                         full_items;

        rst_n      = 1'b0;
        start      = 1'b0;
        operation  = '0;
        data_value = '0;
        position   = '0;
        drop_count = '0;
        model_depth    = 0;
        mismatch_count = 0;
        issued     = 0;
        full_items = 0;
        foreach (model_entries[i])
            model_entries[i] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_command(directed_rows[i].op, directed_rows[i].data, directed_rows[i].pos,
                         directed_rows[i].cnt, directed_rows[i].typed, directed_rows[i].res,
                         1'b1);

        // mixed traffic, then a push-heavy run up to full and a while at full, then mixed again
        repeat (250)
        begin
            pick_command(MIX_MODE, op, data, pos, cnt);
            send_command(op, data, pos, cnt, 1'b0, '0, 1'b1);
            issued++;
        end
        while (full_items < 12)
        begin
            pick_command(FILL_MODE, op, data, pos, cnt);
            send_command(op, data, pos, cnt, 1'b0, '0, 1'b1);
            issued++;
            if (model_depth == STACK_CAP)
                full_items++;
        end
        while (issued < RANDOM_ITEMS)
        begin
            pick_command(MIX_MODE, op, data, pos, cnt);
            send_command(op, data, pos, cnt, 1'b0, '0, issued < RANDOM_ITEMS - QUIET_TAIL);
            issued++;
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (STACK_CAP + 8) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: indexed_lifo_stack_top.f
rtl/lis_pkg.sv
rtl/lis_cell.sv
rtl/indexed_lifo_stack_top.sv
rtl/lis_checker.sv
tb/indexed_lifo_stack_top_test.sv
